// ===== rtl/core/cfps_pkg.sv =====
// ---------------------------------------------------------------------------
// cfps_pkg - shared types and constants for the feedforward PWM slew block
// Field widths, register indexes, reset values and the configuration struct.
// ---------------------------------------------------------------------------
package cfps_pkg;

	// Field widths
	localparam int unsigned CurrentW = 14;
	localparam int unsigned NominalW = 15;
	localparam int unsigned GainW    = 16;
	localparam int unsigned DutyW    = 7;
	localparam int unsigned ProductW = CurrentW + GainW;
	localparam int unsigned SumW     = 32;
	localparam int unsigned PctW     = SumW - 16;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgIdxW  = 2;

	// Register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_NOMINAL_DUTY = 2'd0,
		REG_DUTY_PER_AMP = 2'd1,
		REG_DUTY_CEILING = 2'd2,
		REG_DUTY_FLOOR   = 2'd3
	} cfg_reg_t;

	// Reset values
	localparam logic [NominalW-1:0]     NominalReset = 15'd12800;
	localparam logic signed [GainW-1:0] GainReset    = 16'sd0;
	localparam logic [DutyW-1:0]        CeilingReset = 7'd98;
	localparam logic [DutyW-1:0]        FloorReset   = 7'd25;

	// Slew step in whole percent
	localparam logic [DutyW-1:0] DutyStep = 7'd1;

	// Configuration seen by the target calculation
	typedef struct packed {
		logic [NominalW-1:0] nominal_duty;
		logic [DutyW-1:0]    duty_ceiling;
		logic [DutyW-1:0]    duty_floor;
	} cfps_cfg_t;

endpackage

// ===== rtl/core/cfps_tick_if.sv =====
// ---------------------------------------------------------------------------
// cfps_tick_if - tick channel into the feedforward PWM slew block
// Valid/ready channel carrying the sensed current and move direction.
// ---------------------------------------------------------------------------
interface cfps_tick_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [cfps_pkg::CurrentW-1:0]    motor_current;
	logic                                    move_direction;

	modport source (output valid, output motor_current, output move_direction, input ready);
	modport sink (input valid, input motor_current, input move_direction, output ready);
endinterface

// ---------------------------------------------------------------------------
// cfps_result_if - result channel out of the feedforward PWM slew block
// Valid/ready channel carrying duty, apply strobe and drive direction.
// ---------------------------------------------------------------------------
interface cfps_result_if;
	logic                         valid;
	logic                         ready;
	logic [cfps_pkg::DutyW-1:0]   duty_now;
	logic                         apply_strobe;
	logic                         drive_direction;

	modport source (output valid, output duty_now, output apply_strobe,
		output drive_direction, input ready);
	modport sink (input valid, input duty_now, input apply_strobe,
		input drive_direction, output ready);
endinterface

// ===== rtl/core/cfps_target.sv =====
// ---------------------------------------------------------------------------
// cfps_target - target duty from nominal plus current feedforward
// Adds the gain*current product to the nominal duty, truncates
// toward zero to whole percent and clamps to ceiling, then floor.
// ---------------------------------------------------------------------------
module cfps_target (
	input  cfps_pkg::cfps_cfg_t                          cfg,
	input  logic signed [cfps_pkg::ProductW-1:0]         product,
	output logic [cfps_pkg::DutyW-1:0]                   target
);
	import cfps_pkg::*;

	logic signed [SumW-1:0] sum;
	logic signed [SumW-1:0] sum_adj;
	logic signed [PctW-1:0] pct;
	logic signed [PctW-1:0] ceil_ext;
	logic signed [PctW-1:0] floor_ext;

	// Sum in 1/65536 percent: nominal scaled by 256 plus the product
	assign sum = $signed({{(SumW-NominalW-8){1'b0}}, cfg.nominal_duty, 8'd0})
		+ $signed({{(SumW-ProductW){product[ProductW-1]}}, product});

	// Bias negative sums so the arithmetic shift truncates toward zero
	assign sum_adj = sum[SumW-1] ? (sum + $signed(SumW'(32'hFFFF))) : sum;
	assign pct     = PctW'(sum_adj >>> 16);

	assign ceil_ext  = $signed({{(PctW-DutyW){1'b0}}, cfg.duty_ceiling});
	assign floor_ext = $signed({{(PctW-DutyW){1'b0}}, cfg.duty_floor});

	// Clamp: ceiling test first, then floor
	always_comb begin
		if (pct > ceil_ext) begin
			target = cfg.duty_ceiling;
		end else if (pct < floor_ext) begin
			target = cfg.duty_floor;
		end else begin
			target = pct[DutyW-1:0];
		end
	end

endmodule

// ===== rtl/core/current_feedforward_pwm_slew.sv =====
// ---------------------------------------------------------------------------
// current_feedforward_pwm_slew - current feedforward PWM duty with slew limit
// Recomputes a clamped target duty every TARGET_PERIOD+1 ticks and steps
// the duty one percent toward it every SLEW_PERIOD+1 ticks, and on each recompute, with a strobe.
// ---------------------------------------------------------------------------
//  channel   role    payload                                    per transaction
//  tick      sink    motor_current, move_direction              one tick
//  result    source  duty_now, apply_strobe, drive_direction    one result per tick
//  cfg       write   cfg_we, cfg_index, cfg_data                one register
//
//  One tick transaction per cycle sustained while the result side is ready; its result
//  passes through the input register, then the result register.
//  The 16x14 multiply, add, clamp and slew step sit between the two registers.
//  Reset clears all countdowns, target and duty, and loads register defaults.
//  A stalled result holds the input register; an empty one still takes a tick.
// ---------------------------------------------------------------------------
module current_feedforward_pwm_slew #(
	parameter int unsigned TARGET_PERIOD = 20,
	parameter int unsigned SLEW_PERIOD   = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	cfps_tick_if.sink                            tick,
	cfps_result_if.source                        result,
	input  logic                                 cfg_we,
	input  logic [cfps_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [cfps_pkg::CfgDataW-1:0]        cfg_data
);
	import cfps_pkg::*;

	localparam int unsigned TcW = $clog2(TARGET_PERIOD + 1);
	localparam int unsigned ScW = $clog2(SLEW_PERIOD + 1);

	// Configuration registers
	logic [NominalW-1:0]     nominal_q;
	logic signed [GainW-1:0] gain_q;
	logic [DutyW-1:0]        ceiling_q;
	logic [DutyW-1:0]        floor_q;
	cfps_cfg_t               cfg;

	// Pipeline
	logic                       valid_s1;
	logic signed [CurrentW-1:0] current_s1;
	logic                       dir_s1;
	logic signed [ProductW-1:0] product;
	logic                       out_valid_q;
	logic [DutyW-1:0]           out_duty_q;
	logic                       out_strobe_q;
	logic                       out_dir_q;
	logic                       adv_out;
	logic                       take_in;

	// Block state
	logic [TcW-1:0]   tcount_q;
	logic [ScW-1:0]   scount_q;
	logic [DutyW-1:0] target_q;
	logic [DutyW-1:0] level_q;

	logic [TcW-1:0]   tcount_n;
	logic [ScW-1:0]   scount_n;
	logic [DutyW-1:0] target_n;
	logic [DutyW-1:0] level_n;
	logic             strobe_n;
	logic [DutyW-1:0] calc_target;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q <= NominalReset;
			gain_q    <= GainReset;
			ceiling_q <= CeilingReset;
			floor_q   <= FloorReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NOMINAL_DUTY: nominal_q <= cfg_data[NominalW-1:0];
				REG_DUTY_PER_AMP: gain_q    <= $signed(cfg_data[GainW-1:0]);
				REG_DUTY_CEILING: ceiling_q <= cfg_data[DutyW-1:0];
				REG_DUTY_FLOOR:   floor_q   <= cfg_data[DutyW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.nominal_duty = nominal_q;
	assign cfg.duty_ceiling = ceiling_q;
	assign cfg.duty_floor   = floor_q;

	// Flow control: the input register advances when the result register has room
	assign adv_out    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || adv_out;
	assign take_in    = tick.valid && tick.ready;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (!out_valid_q || result.ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Capture the tick transaction
	always_ff @(posedge clk) begin
		if (take_in) begin
			current_s1 <= tick.motor_current;
			dir_s1     <= tick.move_direction;
		end
	end

	// Feedforward product of the held current and the gain
	assign product = current_s1 * gain_q;

	cfps_target u_target (
		.cfg     (cfg),
		.product (product),
		.target  (calc_target)
	);

	// Next state: target recompute, then slew step
	always_comb begin
		if (tcount_q == '0) begin
			tcount_n = TcW'(TARGET_PERIOD);
			target_n = calc_target;
		end else begin
			tcount_n = tcount_q - TcW'(1);
			target_n = target_q;
		end
		level_n  = level_q;
		strobe_n = 1'b0;
		if ((tcount_q == '0) || (scount_q == '0)) begin
			scount_n = ScW'(SLEW_PERIOD);
			strobe_n = 1'b1;
			if (level_q < target_n) begin
				level_n = level_q + DutyStep;
			end else if (level_q > target_n) begin
				level_n = level_q - DutyStep;
			end
		end else begin
			scount_n = scount_q - ScW'(1);
		end
	end

	// Advance block state with each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q <= '0;
			scount_q <= '0;
			target_q <= '0;
			level_q  <= '0;
		end else if (adv_out) begin
			tcount_q <= tcount_n;
			scount_q <= scount_n;
			target_q <= target_n;
			level_q  <= level_n;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_duty_q   <= level_n;
			out_strobe_q <= strobe_n;
			out_dir_q    <= strobe_n & dir_s1;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.duty_now        = out_duty_q;
	assign result.apply_strobe    = out_strobe_q;
	assign result.drive_direction = out_dir_q;

endmodule

// ===== rtl/core/cfps_checker.sv =====
// ---------------------------------------------------------------------------
// cfps_checker - port-level checks for the feedforward PWM slew block
// Watches the result channel: stall hold, direction and slew behavior of the duty across transactions.
// ---------------------------------------------------------------------------
module cfps_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         result_valid,
	input  logic                         result_ready,
	input  logic [cfps_pkg::DutyW-1:0]   duty_now,
	input  logic                         apply_strobe,
	input  logic                         drive_direction
);
	import cfps_pkg::*;

	logic             seen_q;
	logic [DutyW-1:0] last_duty_q;
	logic [DutyW:0]   duty_ext;
	logic [DutyW:0]   last_ext;

	// Track the duty of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_duty_q <= '0;
		end else if (result_valid && result_ready) begin
			seen_q      <= 1'b1;
			last_duty_q <= duty_now;
		end
	end

	assign duty_ext = {1'b0, duty_now};
	assign last_ext = {1'b0, last_duty_q};

	// Stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(duty_now)
			&& $stable(apply_strobe) && $stable(drive_direction))
		else $error("result changed while stalled");

	// Direction only travels with a strobe
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !apply_strobe |-> !drive_direction)
		else $error("drive direction set without strobe");

	// Duty moves only on a strobe
	a_flat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_q && !apply_strobe |-> duty_now == last_duty_q)
		else $error("duty changed without strobe");

	// Duty moves by at most one step per strobe
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_q && apply_strobe |->
			(duty_ext == last_ext) || (duty_ext == last_ext + 8'd1)
			|| (last_ext == duty_ext + 8'd1))
		else $error("duty jumped by more than one step");

endmodule

bind current_feedforward_pwm_slew cfps_checker u_cfps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.duty_now        (result.duty_now),
	.apply_strobe    (result.apply_strobe),
	.drive_direction (result.drive_direction)
);

// ===== tb/current_feedforward_pwm_slew_test.sv =====
// ---------------------------------------------------------------------------
// current_feedforward_pwm_slew_test - self-checking bench for the PWM slew block
// Drives tick transactions and register writes, predicts every result from
// an independent duty model and checks each result field by field. A short
// directed part covers field and register extremes, then randomized segments
// run under several register settings and back-pressure patterns.
// ---------------------------------------------------------------------------
module current_feedforward_pwm_slew_test;
	import cfps_pkg::*;

	localparam int unsigned TargetPeriod = 20;
	localparam int unsigned SlewPeriod   = 4;
	localparam int unsigned ResetCycles  = 6;
	localparam int unsigned DrainCycles  = 8;
	localparam int unsigned MaxSendGap   = 24;
	localparam int unsigned CycleLimit   = 200000;
	localparam int unsigned Segments     = 12;

	typedef struct packed {
		logic [DutyW-1:0] duty_now;
		logic             apply_strobe;
		logic             drive_direction;
	} duty_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	cfps_tick_if   tick_ch ();
	cfps_result_if result_ch ();

	current_feedforward_pwm_slew #(
		.TARGET_PERIOD(TargetPeriod),
		.SLEW_PERIOD  (SlewPeriod)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// Duty model: register copy and state
	logic [NominalW-1:0]     nominal_r = NominalReset;
	logic signed [GainW-1:0] gain_r    = GainReset;
	logic [DutyW-1:0]        ceiling_r = CeilingReset;
	logic [DutyW-1:0]        floor_r   = FloorReset;
	logic [4:0]              target_cd  = '0;
	logic [2:0]              slew_cd    = '0;
	logic [DutyW-1:0]        target_pct = '0;
	logic [DutyW-1:0]        level_pct  = '0;

	duty_result_t pending_duty_q[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycle_count   = 0;
	int unsigned fail_count    = 0;
	int unsigned ticks_taken   = 0;
	int unsigned results_seen  = 0;
	int unsigned strobes_seen  = 0;
	int unsigned reg_writes    = 0;
	int unsigned settings_used = 1;

	// Feedforward target: exact sum, truncate toward zero, ceiling test first
	function automatic logic [DutyW-1:0] feedforward_target(
			input logic signed [CurrentW-1:0] cur);
		longint sum;
		longint pct;
		sum = longint'(nominal_r) * 256 + longint'(gain_r) * longint'(cur);
		pct = sum / 65536;
		if (pct > longint'(ceiling_r))
			return ceiling_r;
		if (pct < longint'(floor_r))
			return floor_r;
		return pct[DutyW-1:0];
	endfunction

	// Advance the duty model by one tick and return its result
	function automatic duty_result_t step_duty(input logic signed [CurrentW-1:0] cur,
			input logic dir);
		duty_result_t res;
		res = '0;
		if (target_cd == '0) begin
			target_cd  = 5'(TargetPeriod);
			slew_cd    = '0;
			target_pct = feedforward_target(cur);
		end else begin
			target_cd = target_cd - 5'd1;
		end
		if (slew_cd == '0) begin
			slew_cd = 3'(SlewPeriod);
			if (level_pct < target_pct)
				level_pct = level_pct + DutyStep;
			else if (level_pct > target_pct)
				level_pct = level_pct - DutyStep;
			res.apply_strobe    = 1'b1;
			res.drive_direction = dir;
		end else begin
			slew_cd = slew_cd - 3'd1;
		end
		res.duty_now = level_pct;
		return res;
	endfunction

	// Count cycles for the watchdog
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CycleLimit);
		$display("timeout after %0d cycles, %0d results pending", cycle_count,
			pending_duty_q.size());
		$display("current_feedforward_pwm_slew_test: done, errors");
		$finish;
	end

	// Predict on every accepted tick transaction
	always @(posedge clk) begin
		if (arst_n && tick_ch.valid && tick_ch.ready) begin
			pending_duty_q.push_back(step_duty(tick_ch.motor_current,
				tick_ch.move_direction));
			ticks_taken++;
		end
	end

	// Check each result transaction, then pick the next ready
	always @(posedge clk) begin
		duty_result_t exp_r;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (pending_duty_q.size() == 0) begin
				$error("result with no tick pending: duty_now %0d strobe %0b dir %0b",
					result_ch.duty_now, result_ch.apply_strobe, result_ch.drive_direction);
				fail_count++;
			end else begin
				exp_r = pending_duty_q.pop_front();
				if (exp_r.apply_strobe)
					strobes_seen++;
				if (result_ch.duty_now !== exp_r.duty_now) begin
					$error("duty_now: expected %0d, actual %0d", exp_r.duty_now,
						result_ch.duty_now);
					fail_count++;
				end
				if (result_ch.apply_strobe !== exp_r.apply_strobe) begin
					$error("apply_strobe: expected %0b, actual %0b", exp_r.apply_strobe,
						result_ch.apply_strobe);
					fail_count++;
				end
				if (result_ch.drive_direction !== exp_r.drive_direction) begin
					$error("drive_direction: expected %0b, actual %0b",
						exp_r.drive_direction, result_ch.drive_direction);
					fail_count++;
				end
			end
		end
		result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Send one tick transaction; valid stays high for a following one
	task automatic send_tick(input logic signed [CurrentW-1:0] cur, input logic dir);
		int unsigned gap;
		gap = 0;
		while (gap < MaxSendGap && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid          <= 1'b1;
		tick_ch.motor_current  <= cur;
		tick_ch.move_direction <= dir;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	// Drop valid and wait for the pipe to empty
	task automatic quiesce();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_duty_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write all four registers, one per cycle, and mirror them in the model
	task automatic program_regs(input logic [CfgDataW-1:0] nom, input logic [CfgDataW-1:0] gain,
			input logic [CfgDataW-1:0] ceil_v, input logic [CfgDataW-1:0] floor_v);
		logic [CfgDataW-1:0] vals [4];
		cfg_reg_t            reg_idx;
		vals = '{nom, gain, ceil_v, floor_v};
		for (int i = 0; i < 4; i++) begin
			reg_idx = cfg_reg_t'(i);
			cfg_we    <= 1'b1;
			cfg_index <= reg_idx;
			cfg_data  <= vals[i];
			@(posedge clk);
			case (reg_idx)
				REG_NOMINAL_DUTY: nominal_r = vals[i][NominalW-1:0];
				REG_DUTY_PER_AMP: gain_r    = vals[i][GainW-1:0];
				REG_DUTY_CEILING: ceiling_r = vals[i][DutyW-1:0];
				REG_DUTY_FLOOR:   floor_r   = vals[i][DutyW-1:0];
			endcase
			reg_writes++;
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic signed [CurrentW-1:0] pick_current();
		case ($urandom_range(0, 7))
			0:       return -14'sd8192;
			1:       return 14'sd8191;
			2:       return CurrentW'($urandom_range(0, 511) - 256);
			default: return CurrentW'($urandom);
		endcase
	endfunction

	// Choose a register setting: in range, floor over ceiling, extremes, raw bits or random gain
	task automatic pick_settings();
		logic [CfgDataW-1:0] nom;
		logic [CfgDataW-1:0] gain;
		logic [CfgDataW-1:0] ceil_v;
		logic [CfgDataW-1:0] floor_v;
		nom     = CfgDataW'($urandom_range(0, 25600));
		gain    = CfgDataW'($urandom_range(0, 2047) - 1024);
		ceil_v  = CfgDataW'($urandom_range(50, 100));
		floor_v = CfgDataW'($urandom_range(0, ceil_v));
		case ($urandom_range(0, 5))
			0: ;
			1: begin
				nom     = CfgDataW'($urandom);
				gain    = CfgDataW'($urandom);
				ceil_v  = CfgDataW'($urandom);
				floor_v = CfgDataW'($urandom);
			end
			2: begin
				ceil_v  = CfgDataW'($urandom_range(0, 60));
				floor_v = CfgDataW'($urandom_range(ceil_v + 1, 100));
			end
			3: begin
				nom     = '0;
				gain    = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				ceil_v  = '0;
				floor_v = '0;
			end
			4: begin
				nom     = 16'h7FFF;
				gain    = '0;
				ceil_v  = 16'd127;
				floor_v = 16'd127;
			end
			default: begin
				nom     = CfgDataW'(NominalReset);
				gain    = CfgDataW'($urandom);
				ceil_v  = CfgDataW'(CeilingReset);
				floor_v = CfgDataW'(FloorReset);
			end
		endcase
		// Junk in the unused upper data bits must be dropped
		if ($urandom_range(0, 3) == 0) begin
			nom[CfgDataW-1]          = 1'($urandom_range(0, 1));
			ceil_v[CfgDataW-1:DutyW]  = (CfgDataW - DutyW)'($urandom);
			floor_v[CfgDataW-1:DutyW] = (CfgDataW - DutyW)'($urandom);
		end
		program_regs(nom, gain, ceil_v, floor_v);
	endtask

	// Register defaults: first tick computes the target from reset values
	task automatic test_reset_values();
		send_tick(14'sd0, 1'b0);
		send_tick(14'sd0, 1'b1);
		send_tick(14'sd0, 1'b0);
		send_tick(14'sd0, 1'b1);
	endtask

	// Current at both ends of its range, both directions
	task automatic test_current_extremes();
		send_tick(14'sd8191, 1'b1);
		send_tick(-14'sd8192, 1'b0);
		send_tick(-14'sd1, 1'b1);
		send_tick(14'sd1, 1'b0);
		send_tick(14'sd8191, 1'b0);
		send_tick(-14'sd8192, 1'b1);
		send_tick(14'sh1555, 1'b1);
		send_tick(14'sh2AAA, 1'b0);
	endtask

	// Largest nominal and most negative gain; recompute lands on the 22nd tick
	task automatic test_register_extremes();
		quiesce();
		program_regs(16'h7FFF, 16'h8000, 16'd127, 16'd0);
		for (int i = 0; i < 12; i++)
			send_tick(-14'sd8192, i[0]);
	endtask

	// Random segments: sender light / receiver heavy, swapped, then free running
	task automatic test_random_mix();
		int unsigned seg_len;
		for (int seg = 0; seg < Segments; seg++) begin
			quiesce();
			if (seg < Segments / 3) begin
				send_idle_pct = 14;
				recv_idle_pct = 87;
			end else if (seg < 2 * Segments / 3) begin
				send_idle_pct = 87;
				recv_idle_pct = 14;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick_settings();
			seg_len = $urandom_range(80, 195);
			for (int n = 0; n < seg_len; n++)
				send_tick(pick_current(), $urandom_range(0, 1));
		end
	endtask

	initial begin
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= REG_NOMINAL_DUTY;
		cfg_data               <= '0;
		tick_ch.valid          <= 1'b0;
		tick_ch.motor_current  <= '0;
		tick_ch.move_direction <= 1'b0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_current_extremes();
		test_register_extremes();
		test_random_mix();
		quiesce();

		$display("covered %0d ticks and %0d checked results, %0d of them apply strobes",
			ticks_taken, results_seen, strobes_seen);
		$display("under %0d register settings (%0d writes) with both sides stalling",
			settings_used, reg_writes);
		if (fail_count == 0) begin
			$display("current_feedforward_pwm_slew_test: done, clean");
		end else begin
			$display("current_feedforward_pwm_slew_test: done, errors");
		end
		$finish;
	end

endmodule
